[design/gcm_pkg.sv]
`default_nettype none

package gcm_pkg;

  localparam int NumDenoms = 4;
  localparam int AmountW   = 16;
  localparam int CountW    = 8;
  localparam int InUseW    = 3;
  localparam int CfgIdxW   = $clog2(NumDenoms + 1);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegCoinsInUse = CfgIdxW'(NumDenoms);

  localparam logic [NumDenoms-1:0][AmountW-1:0] CoinValueReset = {
    16'd10, 16'd5, 16'd2, 16'd1
  };
  localparam logic [InUseW-1:0] CoinsInUseReset = 3'd4;

  // One request as it travels down the pipeline.
  typedef struct packed {
    logic [AmountW-1:0]                rem;
    logic [NumDenoms-1:0][CountW-1:0]  stock;
    logic [NumDenoms-1:0][CountW-1:0]  used;
  } item_t;

endpackage

`default_nettype wire

[design/greedy_change_maker.sv]
// Greedy change maker with limited coin stock.
//
// A request carries an amount and the coins on hand of each denomination. It
// is taken at a clock edge where in_valid_i is high and in_stall_o is low. The
// block walks the denominations in use from the highest index down and pays
// out as many coins of each as the stock and the remaining amount allow. The
// result (per-denomination counts and the exact flag) leaves on the out_*
// channel and is taken when out_valid_o is high and out_stall_i is low.
//
// The walk runs as a pipeline of one stage per count bit per denomination,
// 32 stages, plus an output register, and one request can be taken every
// cycle while the receiver is not stalling a waiting result.
// When the receiver stalls with a result waiting, the whole pipeline holds;
// bubbles keep moving while the output register is empty.
//
// Reset clears all valid bits and loads the coin values 1, 2, 5 and 10 with
// four denominations in use. Configuration writes belong in idle periods.
`default_nettype none

module greedy_change_maker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [gcm_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [gcm_pkg::AmountW-1:0]   cfg_data_i,
  input  wire logic                          in_valid_i,
  output      logic                          in_stall_o,
  input  wire logic [gcm_pkg::AmountW-1:0]   amount_i,
  input  wire logic [gcm_pkg::CountW-1:0]    stock_0_i,
  input  wire logic [gcm_pkg::CountW-1:0]    stock_1_i,
  input  wire logic [gcm_pkg::CountW-1:0]    stock_2_i,
  input  wire logic [gcm_pkg::CountW-1:0]    stock_3_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_stall_i,
  output      logic                          exact_o,
  output      logic [gcm_pkg::CountW-1:0]    used_0_o,
  output      logic [gcm_pkg::CountW-1:0]    used_1_o,
  output      logic [gcm_pkg::CountW-1:0]    used_2_o,
  output      logic [gcm_pkg::CountW-1:0]    used_3_o
);

  localparam int NumStages = gcm_pkg::NumDenoms * gcm_pkg::CountW;

  logic [gcm_pkg::NumDenoms-1:0][gcm_pkg::AmountW-1:0] coin_value_q;
  logic [gcm_pkg::InUseW-1:0]                          coins_in_use_q;
  logic [gcm_pkg::InUseW-1:0]                          n_eff;
  logic [gcm_pkg::NumDenoms-1:0]                       denom_on;

  logic                                   en;
  logic [NumStages:0]                     vld;
  gcm_pkg::item_t                         item [NumStages+1];

  logic                                   out_vld_q;
  logic                                   exact_q;
  logic [gcm_pkg::NumDenoms-1:0][gcm_pkg::CountW-1:0] used_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coin_value_q   <= gcm_pkg::CoinValueReset;
      coins_in_use_q <= gcm_pkg::CoinsInUseReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < gcm_pkg::RegCoinsInUse) begin
        coin_value_q[cfg_idx_i[$clog2(gcm_pkg::NumDenoms)-1:0]] <= cfg_data_i;
      end else if (cfg_idx_i == gcm_pkg::RegCoinsInUse) begin
        coins_in_use_q <= cfg_data_i[gcm_pkg::InUseW-1:0];
      end
    end
  end

  always_comb begin
    if (coins_in_use_q > gcm_pkg::InUseW'(gcm_pkg::NumDenoms)) begin
      n_eff = gcm_pkg::InUseW'(gcm_pkg::NumDenoms);
    end else begin
      n_eff = coins_in_use_q;
    end
    for (int d = 0; d < gcm_pkg::NumDenoms; d++) begin
      denom_on[d] = (n_eff > gcm_pkg::InUseW'(d)) && (coin_value_q[d] != '0);
    end
  end

  // The pipeline holds only while a finished result is refused.
  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    vld[0]            = in_valid_i;
    item[0].rem       = amount_i;
    item[0].stock[0]  = stock_0_i;
    item[0].stock[1]  = stock_1_i;
    item[0].stock[2]  = stock_2_i;
    item[0].stock[3]  = stock_3_i;
    item[0].used      = '0;
  end

  for (genvar k = 0; k < NumStages; k++) begin : g_stage
    localparam int D = gcm_pkg::NumDenoms - 1 - (k / gcm_pkg::CountW);
    localparam int B = gcm_pkg::CountW - 1 - (k % gcm_pkg::CountW);

    gcm_bit_stage #(
      .Denom (D),
      .Bit   (B)
    ) u_stage (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .en_i         (en),
      .in_use_i     (denom_on[D]),
      .coin_value_i (coin_value_q[D]),
      .vld_i        (vld[k]),
      .item_i       (item[k]),
      .vld_o        (vld[k+1]),
      .item_o       (item[k+1])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      exact_q <= (item[NumStages].rem == '0);
      used_q  <= item[NumStages].used;
    end
  end

  assign out_valid_o = out_vld_q;
  assign exact_o     = exact_q;
  assign used_0_o    = used_q[0];
  assign used_1_o    = used_q[1];
  assign used_2_o    = used_q[2];
  assign used_3_o    = used_q[3];

endmodule

`default_nettype wire

[design/gcm_bit_stage.sv]
`default_nettype none

module gcm_bit_stage #(
  parameter int Denom = 0,
  parameter int Bit   = 0
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          in_use_i,
  input  wire logic [gcm_pkg::AmountW-1:0]   coin_value_i,
  input  wire logic                          vld_i,
  input  wire gcm_pkg::item_t                item_i,
  output      logic                          vld_o,
  output      gcm_pkg::item_t                item_o
);

  localparam int AccW = gcm_pkg::AmountW + gcm_pkg::CountW;

  logic [gcm_pkg::CountW-1:0] trial_cnt;
  logic [AccW-1:0]            shifted;
  logic [AccW:0]              diff;
  logic                       take;
  gcm_pkg::item_t             item_d;
  gcm_pkg::item_t             item_q;
  logic                       vld_q;

  // Setting count bits from the top finds the largest count that both fits
  // the stock and keeps the remainder non-negative, since the valid counts
  // form a range starting at zero.
  always_comb begin
    trial_cnt = item_i.used[Denom] | (gcm_pkg::CountW'(1) << Bit);
    shifted   = {{gcm_pkg::CountW{1'b0}}, coin_value_i} << Bit;
    diff      = {1'b0, {gcm_pkg::CountW{1'b0}}, item_i.rem} - {1'b0, shifted};
    take      = in_use_i && !diff[AccW] && (trial_cnt <= item_i.stock[Denom]);
    item_d    = item_i;
    if (take) begin
      item_d.used[Denom] = trial_cnt;
      item_d.rem         = diff[gcm_pkg::AmountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int QuietLimit = 3000;
  localparam int DrainCycles = 40;
  localparam logic [gcm_pkg::CfgIdxW-1:0] RegCoinValue0 = '0;

  typedef logic [gcm_pkg::NumDenoms-1:0][gcm_pkg::CountW-1:0] counts_t;

  typedef struct packed {
    logic    exact;
    counts_t used;
  } payout_t;

  // Keeps its own copy of the coin registers, predicts the payout of each
  // accepted request and compares the results in order.
  class payout_board_t;
    logic [gcm_pkg::AmountW-1:0] coin_value [gcm_pkg::NumDenoms];
    logic [gcm_pkg::InUseW-1:0]  coins_in_use;
    payout_t                     pending_payouts [$];
    int                          errors;

    function new();
      for (int i = 0; i < gcm_pkg::NumDenoms; i++) begin
        coin_value[i] = gcm_pkg::CoinValueReset[i];
      end
      coins_in_use = gcm_pkg::CoinsInUseReset;
      errors = 0;
    endfunction

    function void set_register(int unsigned idx, logic [gcm_pkg::AmountW-1:0] data);
      if (idx < gcm_pkg::NumDenoms) coin_value[idx] = data;
      else if (idx == gcm_pkg::RegCoinsInUse) coins_in_use = data[gcm_pkg::InUseW-1:0];
    endfunction

    function payout_t pay_out(logic [gcm_pkg::AmountW-1:0] amount, counts_t stock);
      payout_t     r;
      int unsigned rem;
      int unsigned v;
      int unsigned take;
      int          n;
      rem = amount;
      n = (coins_in_use > gcm_pkg::NumDenoms) ? gcm_pkg::NumDenoms : coins_in_use;
      r.used = '0;
      for (int i = n - 1; i >= 0 && rem > 0; i--) begin
        v = coin_value[i];
        // Zero-valued coins, empty stock and coins above the remainder pay nothing.
        if (v != 0 && stock[i] != 0 && v <= rem) begin
          take = rem / v;
          if (take > stock[i]) take = stock[i];
          r.used[i] = take[gcm_pkg::CountW-1:0];
          rem = rem - take * v;
        end
      end
      r.exact = (rem == 0);
      return r;
    endfunction

    function void note_request(logic [gcm_pkg::AmountW-1:0] amount, counts_t stock);
      pending_payouts.push_back(pay_out(amount, stock));
    endfunction

    function void check_result(logic exact, counts_t used);
      payout_t want;
      if (pending_payouts.size() == 0) begin
        $display("%0t: result with no request pending (exact %0d)", $time, exact);
        errors++;
        return;
      end
      want = pending_payouts.pop_front();
      if (exact !== want.exact) begin
        $display("%0t: exact expected %0d, got %0d", $time, want.exact, exact);
        errors++;
      end
      for (int i = 0; i < gcm_pkg::NumDenoms; i++) begin
        if (used[i] !== want.used[i]) begin
          $display("%0t: used_%0d expected %0d, got %0d", $time, i, want.used[i], used[i]);
          errors++;
        end
      end
    endfunction

    function int outstanding();
      return pending_payouts.size();
    endfunction
  endclass

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [gcm_pkg::CfgIdxW-1:0]   cfg_idx_i;
  logic [gcm_pkg::AmountW-1:0]   cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [gcm_pkg::AmountW-1:0]   amount_i;
  logic [gcm_pkg::CountW-1:0]    stock_0_i;
  logic [gcm_pkg::CountW-1:0]    stock_1_i;
  logic [gcm_pkg::CountW-1:0]    stock_2_i;
  logic [gcm_pkg::CountW-1:0]    stock_3_i;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          exact_o;
  logic [gcm_pkg::CountW-1:0]    used_0_o;
  logic [gcm_pkg::CountW-1:0]    used_1_o;
  logic [gcm_pkg::CountW-1:0]    used_2_o;
  logic [gcm_pkg::CountW-1:0]    used_3_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  payout_board_t board = new();

  greedy_change_maker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .amount_i    (amount_i),
    .stock_0_i   (stock_0_i),
    .stock_1_i   (stock_1_i),
    .stock_2_i   (stock_2_i),
    .stock_3_i   (stock_3_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .exact_o     (exact_o),
    .used_0_o    (used_0_o),
    .used_1_o    (used_1_o),
    .used_2_o    (used_2_o),
    .used_3_o    (used_3_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: check what was taken at this edge, then pick the next stall.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      board.check_result(exact_o, {used_3_o, used_2_o, used_1_o, used_0_o});
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_request(logic [gcm_pkg::AmountW-1:0] amount, counts_t stock);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    amount_i   <= amount;
    stock_0_i  <= stock[0];
    stock_1_i  <= stock[1];
    stock_2_i  <= stock[2];
    stock_3_i  <= stock[3];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(amount, stock);
  endtask

  // Writes every register in turn; stray also writes the unused indexes,
  // which must leave the configuration alone.
  task automatic apply_setting(
    logic [gcm_pkg::NumDenoms-1:0][gcm_pkg::AmountW-1:0] values,
    logic [gcm_pkg::InUseW-1:0] in_use, bit stray);
    logic [gcm_pkg::AmountW-1:0] data;
    for (int i = 0; i < gcm_pkg::NumDenoms + 1; i++) begin
      if (i < gcm_pkg::NumDenoms) begin
        data = values[i];
      end else begin
        data = gcm_pkg::AmountW'($urandom);
        data[gcm_pkg::InUseW-1:0] = in_use;
      end
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= (i < gcm_pkg::NumDenoms) ? RegCoinValue0 + gcm_pkg::CfgIdxW'(i)
                                             : gcm_pkg::RegCoinsInUse;
      cfg_data_i <= data;
      @(posedge clk_i);
      board.set_register(i, data);
    end
    if (stray) begin
      for (int k = gcm_pkg::RegCoinsInUse + 1; k < (1 << gcm_pkg::CfgIdxW); k++) begin
        data = gcm_pkg::AmountW'($urandom);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= gcm_pkg::CfgIdxW'(k);
        cfg_data_i <= data;
        @(posedge clk_i);
        board.set_register(k, data);
      end
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_setting();
    logic [gcm_pkg::NumDenoms-1:0][gcm_pkg::AmountW-1:0] values;
    logic [gcm_pkg::InUseW-1:0]                          in_use;
    int unsigned                                         step;
    int unsigned                                         acc;
    case ($urandom_range(2))
      0, 1: begin
        // Ascending coin values, either close together or spread wide.
        step = $urandom_range(1) ? 20 : 16000;
        acc = $urandom_range(1, 20);
        for (int i = 0; i < gcm_pkg::NumDenoms; i++) begin
          values[i] = acc[gcm_pkg::AmountW-1:0];
          acc = acc + $urandom_range(step);
        end
      end
      default: begin
        for (int i = 0; i < gcm_pkg::NumDenoms; i++) begin
          values[i] = ($urandom_range(4) == 0) ? '0 : gcm_pkg::AmountW'($urandom);
        end
      end
    endcase
    in_use = $urandom_range(1) ? gcm_pkg::InUseW'(gcm_pkg::NumDenoms)
                               : gcm_pkg::InUseW'($urandom_range(7));
    apply_setting(values, in_use, 1'($urandom_range(1)));
  endtask

  task automatic send_random_request();
    counts_t                     stock;
    logic [31:0]                 total;
    logic [gcm_pkg::AmountW-1:0] amount;
    for (int i = 0; i < gcm_pkg::NumDenoms; i++) begin
      case ($urandom_range(4))
        0, 1:    stock[i] = gcm_pkg::CountW'($urandom_range(255));
        2:       stock[i] = gcm_pkg::CountW'($urandom_range(4));
        3:       stock[i] = '1;
        default: stock[i] = '0;
      endcase
    end
    case ($urandom_range(3))
      0, 1: begin
        // Build the amount from coins actually on hand, so it is often payable.
        total = 0;
        for (int i = 0; i < gcm_pkg::NumDenoms; i++) begin
          total = total + $urandom_range(stock[i]) * board.coin_value[i];
        end
        amount = total[gcm_pkg::AmountW-1:0];
      end
      2:       amount = gcm_pkg::AmountW'($urandom_range(300));
      default: amount = gcm_pkg::AmountW'($urandom);
    endcase
    send_request(amount, stock);
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    amount_i   <= '0;
    stock_0_i  <= '0;
    stock_1_i  <= '0;
    stock_2_i  <= '0;
    stock_3_i  <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset coins 1, 2, 5, 10 with all four in use.
    send_request(16'd0, {4{8'd255}});
    send_request(16'hFFFF, {4{8'd255}});
    send_request(16'hFFFF, '0);
    send_request(16'd18, {8'd1, 8'd1, 8'd1, 8'd1});
    send_request(16'd7, {8'd0, 8'd1, 8'd0, 8'd3});
    send_request(16'd3, {8'd255, 8'd255, 8'd1, 8'd0});
    send_request(16'd4590, {4{8'd255}});
    wait_idle();

    // No denomination in use.
    apply_setting({4{16'hFFFF}}, 3'd0, 1'b0);
    send_request(16'd0, {4{8'd255}});
    send_request(16'd1, {4{8'd255}});
    wait_idle();

    // More in use than exist, largest coin values.
    apply_setting({4{16'hFFFF}}, 3'd7, 1'b0);
    send_request(16'hFFFF, {4{8'd255}});
    send_request(16'hFFFE, {4{8'd255}});
    wait_idle();

    // Zero-valued coins are skipped.
    apply_setting({16'd7, 16'd0, 16'd3, 16'd0}, 3'd5, 1'b0);
    send_request(16'd20, {4{8'd255}});
    send_request(16'd1, {4{8'd255}});
    wait_idle();

    // Coin values out of order, plus writes to unused register indexes.
    apply_setting({16'd20, 16'd1, 16'd4, 16'd9}, 3'd4, 1'b1);
    send_request(16'd33, {4{8'd255}});
    send_request(16'd300, {8'd3, 8'd255, 8'd2, 8'd7});
    wait_idle();

    // Only the two lowest denominations in use.
    apply_setting({16'd10, 16'd5, 16'd2, 16'd1}, 3'd2, 1'b0);
    send_request(16'd100, {4{8'd255}});
    send_request(16'd1000, {8'd255, 8'd255, 8'd100, 8'd100});
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      random_setting();
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 20; recv_stall_pct = 20; end
      endcase
      repeat (140) send_random_request();
      wait_idle();
    end

    // Give a stray extra result time to show up.
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
design/gcm_pkg.sv
design/gcm_bit_stage.sv
design/greedy_change_maker.sv
test/testbench.sv
